/* rtl/led_flash_blink_sequencer_defines.svh */
// assertion macros used by the checker file
`ifndef LED_FLASH_BLINK_SEQUENCER_DEFINES_SVH
`define LED_FLASH_BLINK_SEQUENCER_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define LFBS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lfbs check failed: same-cycle implication");

// next-cycle implication, held off while reset is low
`define LFBS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lfbs check failed: next-cycle implication");

`endif

/* rtl/lfbs_pkg.sv */
`default_nettype none

package lfbs_pkg;

    // default width of the countdown timer
    localparam int TIME_BITS_DEF = 16;

    // field widths
    localparam int ACTION_W = 3;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 2;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;
    localparam int RESULT_W    = 20;

    // command codes
    localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ENABLE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ON        = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_OFF       = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FLASH     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_BLINK_ON  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_BLINK_OFF = 3'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_PRIORITY = 2'd1;

    typedef struct packed {
        logic [COUNT_W-1:0]  gap_interval;
        logic [COUNT_W-1:0]  on_duration;
        logic [COUNT_W-1:0]  quantity_or_flag;
        logic [ACTION_W-1:0] action;
    } lfbs_item_t;

    typedef struct packed {
        logic active_high;
        logic blink_priority;
    } lfbs_cfg_t;

    // last member sits in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0] hold_level;
        logic               blink_running;
        logic               flash_running;
        logic               led_lit;
        logic               led_pin;
    } lfbs_result_t;

endpackage

`default_nettype wire

/* rtl/lfbs_core.sv */
`default_nettype none

module lfbs_core #(
    parameter int TIME_BITS = lfbs_pkg::TIME_BITS_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   step,
    input  lfbs_pkg::lfbs_item_t  item,
    input  lfbs_pkg::lfbs_cfg_t   cfg,
    output lfbs_pkg::lfbs_result_t result
);
    import lfbs_pkg::*;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // saturate a 16-bit duration into the timer width
    function automatic logic [TIME_BITS-1:0] time_sat(input logic [COUNT_W-1:0] v);
        logic [31:0] v32;
        logic [31:0] m32;
        v32 = 32'(v);
        m32 = 32'(TIME_MAX);
        if (v32 > m32)
        begin
            return TIME_MAX;
        end
        return TIME_BITS'(v32);
    endfunction

    logic                 lit_reg, lit_next;
    logic                 enabled_reg, enabled_next;
    logic [COUNT_W-1:0]   hold_reg, hold_next;
    logic                 flash_mode_reg, flash_mode_next;
    logic [COUNT_W-1:0]   flash_lit_reg, flash_lit_next;
    logic [COUNT_W-1:0]   flash_pulses_reg, flash_pulses_next;
    logic [COUNT_W-1:0]   flash_gap_reg, flash_gap_next;
    logic [COUNT_W-1:0]   flash_done_reg, flash_done_next;
    logic                 blink_mode_reg, blink_mode_next;
    logic [COUNT_W-1:0]   blink_lit_reg, blink_lit_next;
    logic [COUNT_W-1:0]   blink_pulses_reg, blink_pulses_next;
    logic [COUNT_W-1:0]   blink_gap_reg, blink_gap_next;
    logic [COUNT_W-1:0]   blink_done_reg, blink_done_next;
    logic [TIME_BITS-1:0] period_reg, period_next;
    logic                 forever_reg, forever_next;
    logic [TIME_BITS-1:0] ticks_reg, ticks_next;

    logic                 flag;
    logic [COUNT_W-1:0]   flash_inc;
    logic [COUNT_W-1:0]   blink_inc;

    assign flag      = (item.quantity_or_flag != '0);
    assign flash_inc = flash_done_reg + COUNT_W'(1);
    assign blink_inc = blink_done_reg + COUNT_W'(1);

    // next state for one command or tick
    always_comb
    begin
        lit_next          = lit_reg;
        enabled_next      = enabled_reg;
        hold_next         = hold_reg;
        flash_mode_next   = flash_mode_reg;
        flash_lit_next    = flash_lit_reg;
        flash_pulses_next = flash_pulses_reg;
        flash_gap_next    = flash_gap_reg;
        flash_done_next   = flash_done_reg;
        blink_mode_next   = blink_mode_reg;
        blink_lit_next    = blink_lit_reg;
        blink_pulses_next = blink_pulses_reg;
        blink_gap_next    = blink_gap_reg;
        blink_done_next   = blink_done_reg;
        period_next       = period_reg;
        forever_next      = forever_reg;
        ticks_next        = ticks_reg;

        case (item.action)
            ACT_TICK:
            begin
                if (!forever_reg)
                begin
                    if (ticks_reg != '0)
                    begin
                        ticks_next = ticks_reg - TIME_BITS'(1);
                    end
                    if (ticks_next == '0)
                    begin
                        // one series step
                        if (flash_mode_reg)
                        begin
                            if (lit_reg)
                            begin
                                if (flash_inc >= flash_pulses_reg)
                                begin
                                    // series finished
                                    flash_done_next = '0;
                                    flash_mode_next = 1'b0;
                                    if (hold_reg == '0)
                                    begin
                                        if (cfg.blink_priority && blink_mode_reg)
                                        begin
                                            forever_next    = 1'b0;
                                            period_next     = time_sat(blink_gap_reg);
                                            blink_done_next = '0;
                                        end
                                        else
                                        begin
                                            blink_mode_next = 1'b0;
                                            forever_next    = 1'b1;
                                        end
                                        lit_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    flash_done_next = flash_inc;
                                    forever_next    = 1'b0;
                                    period_next     = time_sat(flash_gap_reg);
                                    lit_next        = 1'b0;
                                end
                            end
                            else
                            begin
                                forever_next = 1'b0;
                                period_next  = time_sat(flash_lit_reg);
                                lit_next     = 1'b1;
                            end
                        end
                        else if (blink_mode_reg)
                        begin
                            forever_next = 1'b0;
                            if (lit_reg)
                            begin
                                if (blink_inc >= blink_pulses_reg)
                                begin
                                    blink_done_next = '0;
                                    period_next     = time_sat(blink_gap_reg);
                                end
                                else
                                begin
                                    blink_done_next = blink_inc;
                                    period_next     = time_sat(blink_lit_reg);
                                end
                                lit_next = 1'b0;
                            end
                            else
                            begin
                                period_next = time_sat(blink_lit_reg);
                                lit_next    = 1'b1;
                            end
                        end
                        if (!forever_next)
                        begin
                            ticks_next = period_next;
                        end
                    end
                end
            end
            ACT_ENABLE:
            begin
                enabled_next = flag;
                ticks_next   = period_next;
            end
            ACT_ON:
            begin
                if (flag && hold_reg != '1)
                begin
                    hold_next = hold_reg + COUNT_W'(1);
                end
                if (!cfg.blink_priority)
                begin
                    flash_mode_next = 1'b0;
                    blink_mode_next = 1'b0;
                end
                forever_next = 1'b1;
                lit_next     = 1'b1;
                ticks_next   = period_next;
            end
            ACT_OFF:
            begin
                if (flag && hold_reg != '0)
                begin
                    hold_next = hold_reg - COUNT_W'(1);
                end
                if (hold_next == '0)
                begin
                    if (cfg.blink_priority)
                    begin
                        if (flash_mode_reg && flash_gap_reg != '0)
                        begin
                            forever_next = 1'b0;
                            period_next  = time_sat(flash_gap_reg);
                        end
                        else if (blink_mode_reg && blink_gap_reg != '0)
                        begin
                            forever_next    = 1'b0;
                            period_next     = time_sat(blink_gap_reg);
                            blink_done_next = '0;
                        end
                        else
                        begin
                            forever_next = 1'b1;
                        end
                    end
                    else
                    begin
                        flash_mode_next = 1'b0;
                        blink_mode_next = 1'b0;
                        forever_next    = 1'b1;
                    end
                    lit_next = 1'b0;
                end
                ticks_next = period_next;
            end
            ACT_FLASH:
            begin
                flash_mode_next   = 1'b1;
                flash_lit_next    = item.on_duration;
                flash_pulses_next = item.quantity_or_flag;
                flash_gap_next    = item.gap_interval;
                flash_done_next   = '0;
                if (!cfg.blink_priority)
                begin
                    blink_mode_next = 1'b0;
                end
                if (hold_reg == '0)
                begin
                    forever_next = 1'b0;
                    period_next  = '0;
                    lit_next     = 1'b0;
                end
                ticks_next = period_next;
            end
            ACT_BLINK_ON:
            begin
                blink_mode_next   = 1'b1;
                blink_lit_next    = item.on_duration;
                blink_pulses_next = item.quantity_or_flag;
                blink_gap_next    = item.gap_interval;
                blink_done_next   = '0;
                if (hold_reg == '0 && !flash_mode_reg)
                begin
                    forever_next = 1'b0;
                    period_next  = '0;
                    lit_next     = 1'b0;
                end
                ticks_next = period_next;
            end
            ACT_BLINK_OFF:
            begin
                if (blink_mode_reg)
                begin
                    blink_mode_next = 1'b0;
                    flash_mode_next = 1'b0;
                    if (hold_reg == '0)
                    begin
                        lit_next = 1'b0;
                    end
                    forever_next = 1'b1;
                end
                ticks_next = period_next;
            end
            default:
            begin
                // unused code leaves everything as it is
            end
        endcase
    end

    // result seen after this beat
    always_comb
    begin
        result.led_pin       = (enabled_next && lit_next) ? cfg.active_high
                                                          : ~cfg.active_high;
        result.led_lit       = lit_next;
        result.flash_running = flash_mode_next;
        result.blink_running = blink_mode_next;
        result.hold_level    = hold_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg        <= 1'b0;
            enabled_reg    <= 1'b1;
            hold_reg       <= '0;
            flash_mode_reg <= 1'b0;
            flash_done_reg <= '0;
            blink_mode_reg <= 1'b0;
            blink_done_reg <= '0;
            period_reg     <= '0;
            forever_reg    <= 1'b1;
            ticks_reg      <= '0;
        end
        else if (step)
        begin
            lit_reg        <= lit_next;
            enabled_reg    <= enabled_next;
            hold_reg       <= hold_next;
            flash_mode_reg <= flash_mode_next;
            flash_done_reg <= flash_done_next;
            blink_mode_reg <= blink_mode_next;
            blink_done_reg <= blink_done_next;
            period_reg     <= period_next;
            forever_reg    <= forever_next;
            ticks_reg      <= ticks_next;
        end
    end

    // series settings, reset to zero as well
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_lit_reg    <= '0;
            flash_pulses_reg <= '0;
            flash_gap_reg    <= '0;
            blink_lit_reg    <= '0;
            blink_pulses_reg <= '0;
            blink_gap_reg    <= '0;
        end
        else if (step)
        begin
            flash_lit_reg    <= flash_lit_next;
            flash_pulses_reg <= flash_pulses_next;
            flash_gap_reg    <= flash_gap_next;
            blink_lit_reg    <= blink_lit_next;
            blink_pulses_reg <= blink_pulses_next;
            blink_gap_reg    <= blink_gap_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/led_flash_blink_sequencer.sv */
`default_nettype none

// LED flash/blink sequencer: each input beat is a tick or a command, and each one
// gives exactly one status beat (pin level, lit state, series flags, hold count).
// The whole state update is combinational between the input handshake and the
// output register, so one beat is taken every clock while the skid stage is empty;
// the result goes to the output register, or to a one-entry skid stage while the
// master side stalls, so input beats keep flowing while one result waits.
// Configuration writes are always taken and should only be made while idle.
module led_flash_blink_sequencer #(
    parameter int TIME_BITS = lfbs_pkg::TIME_BITS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // cfg channel
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [lfbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire                              cfg_data,
    // slave side
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // action, quantity_or_flag, on_duration, gap_interval, zero pad
    input  wire  [lfbs_pkg::IN_TDATA_W-1:0]  s_tdata,
    // master side
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // led_pin, led_lit, flash_running, blink_running, hold_level, zero pad
    output logic [lfbs_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import lfbs_pkg::*;

    lfbs_cfg_t    cfg_reg;
    lfbs_item_t   item;
    lfbs_result_t result;
    lfbs_result_t out_data_reg;
    lfbs_result_t skid_data_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         in_beat;
    logic         out_beat;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_beat   = s_tvalid && s_tready;
    assign out_beat  = out_valid_reg && m_tready;

    // unpack the input beat
    assign item.action           = s_tdata[2:0];
    assign item.quantity_or_flag = s_tdata[18:3];
    assign item.on_duration      = s_tdata[34:19];
    assign item.gap_interval     = s_tdata[50:35];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_high    <= 1'b1;
            cfg_reg.blink_priority <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACTIVE_HIGH:    cfg_reg.active_high    <= cfg_data;
                REG_BLINK_PRIORITY: cfg_reg.blink_priority <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    lfbs_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (in_beat),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result)
    );

    // output register and skid stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_beat)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_beat;
            end
        end
        else if (in_beat)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output register and skid stage data
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_beat)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (in_beat)
        begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), out_data_reg};

endmodule

`default_nettype wire

/* rtl/lfbs_checker.sv */
`default_nettype none

`include "led_flash_blink_sequencer_defines.svh"

module lfbs_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [lfbs_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import lfbs_pkg::*;

    // a stalled result beat holds
    `LFBS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // input back-pressure only while a result is waiting
    `LFBS_ASSERT_NOW(a_ready_low, clk, rst_n, !s_tready, m_tvalid)

    // an accepted beat always leaves a result beat valid next cycle
    `LFBS_ASSERT_NEXT(a_result_follows, clk, rst_n, s_tvalid && s_tready, m_tvalid)

    // a nonzero hold count keeps the LED lit
    `LFBS_ASSERT_NOW(a_hold_lit, clk, rst_n, m_tvalid && m_tdata[19:4] != 16'd0, m_tdata[1])

endmodule

bind led_flash_blink_sequencer lfbs_checker u_lfbs_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import lfbs_pkg::*;

    // code 7 is not a command: the block must leave everything alone
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

    // one line of the directed script; config rows carry the register index in qty
    // and the value in dur[0]; want is {hold, blink, flash, lit, pin}
    typedef struct packed {
        row_kind_e          kind;
        logic [ACTION_W-1:0] action;
        logic [COUNT_W-1:0] qty;
        logic [COUNT_W-1:0] dur;
        logic [COUNT_W-1:0] gap;
        logic               typed;
        lfbs_result_t       want;
    } stim_row_t;

    localparam stim_row_t SCRIPT [29] = '{
        // after reset, then the ignored code with every field at its top
        '{ROW_BEAT, ACT_TICK,      16'd0,    16'd0,    16'd0,    1'b1, {16'd0, 4'b0000}},
        '{ROW_BEAT, ACT_UNUSED,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, {16'd0, 4'b0000}},
        // fixed and plain steady on, enable masking, fixed off
        '{ROW_BEAT, ACT_ON,        16'hFFFF, 16'd0,    16'd0,    1'b1, {16'd1, 4'b0011}},
        '{ROW_BEAT, ACT_ON,        16'd0,    16'd0,    16'd0,    1'b1, {16'd1, 4'b0011}},
        '{ROW_BEAT, ACT_ENABLE,    16'd0,    16'd0,    16'd0,    1'b1, {16'd1, 4'b0010}},
        '{ROW_BEAT, ACT_ENABLE,    16'hFFFF, 16'd0,    16'd0,    1'b1, {16'd1, 4'b0011}},
        '{ROW_BEAT, ACT_OFF,       16'd1,    16'd0,    16'd0,    1'b1, {16'd0, 4'b0000}},
        // two flashes with no gap, run to the end
        '{ROW_BEAT, ACT_FLASH,     16'd2,    16'd1,    16'd0,    1'b0, '0},
        '{ROW_BEAT, ACT_TICK,      16'd0,    16'd0,    16'd0,    1'b0, '0},
        '{ROW_BEAT, ACT_TICK,      16'd0,    16'd0,    16'd0,    1'b0, '0},
        '{ROW_BEAT, ACT_TICK,      16'd0,    16'd0,    16'd0,    1'b0, '0},
        '{ROW_BEAT, ACT_TICK,      16'd0,    16'd0,    16'd0,    1'b0, '0},
        // flash series with a zero pulse count
        '{ROW_BEAT, ACT_FLASH,     16'd0,    16'd0,    16'd0,    1'b0, '0},
        '{ROW_BEAT, ACT_TICK,      16'd0,    16'd0,    16'd0,    1'b0, '0},
        '{ROW_BEAT, ACT_TICK,      16'd0,    16'd0,    16'd0,    1'b0, '0},
        // blink with a zero pulse count goes to the gap after each pulse
        '{ROW_BEAT, ACT_BLINK_ON,  16'd0,    16'd1,    16'd2,    1'b0, '0},
        '{ROW_BEAT, ACT_TICK,      16'd0,    16'd0,    16'd0,    1'b0, '0},
        '{ROW_BEAT, ACT_TICK,      16'd0,    16'd0,    16'd0,    1'b0, '0},
        '{ROW_BEAT, ACT_TICK,      16'd0,    16'd0,    16'd0,    1'b0, '0},
        '{ROW_BEAT, ACT_BLINK_OFF, 16'd0,    16'd0,    16'd0,    1'b0, '0},
        // steady light suspends: flash with zero gap stays parked after off
        '{ROW_CFG,  ACT_TICK,      16'(REG_BLINK_PRIORITY), 16'd1, 16'd0, 1'b0, '0},
        '{ROW_BEAT, ACT_FLASH,     16'd1,    16'd3,    16'd0,    1'b0, '0},
        '{ROW_BEAT, ACT_ON,        16'd1,    16'd0,    16'd0,    1'b0, '0},
        '{ROW_BEAT, ACT_OFF,       16'd1,    16'd0,    16'd0,    1'b0, '0},
        '{ROW_BEAT, ACT_TICK,      16'd0,    16'd0,    16'd0,    1'b0, '0},
        '{ROW_BEAT, ACT_BLINK_ON,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{ROW_BEAT, ACT_BLINK_OFF, 16'd0,    16'd0,    16'd0,    1'b0, '0},
        // inverted polarity, everything dark
        '{ROW_CFG,  ACT_TICK,      16'(REG_ACTIVE_HIGH), 16'd0, 16'd0, 1'b0, '0},
        '{ROW_BEAT, ACT_TICK,      16'd0,    16'd0,    16'd0,    1'b1, {16'd0, 4'b0001}}
    };

    // register settings for the random phases
    localparam logic PHASE_AH   [4] = '{1'b1, 1'b0, 1'b1, 1'b0};
    localparam logic PHASE_PRIO [4] = '{1'b0, 1'b1, 1'b1, 1'b0};

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic                       cfg_data;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_TDATA_W-1:0]      s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_TDATA_W-1:0]     m_tdata;

    logic                       steady_run;
    int unsigned                fail_count;
    lfbs_result_t               expected_status [$];
    lfbs_result_t               seen_status;
    lfbs_result_t               want_status;

    // predictor copy of the registers and the sequencer state
    logic                       cfg_active_high;
    logic                       cfg_blink_prio;
    logic                       lamp_lit;
    logic                       out_enable;
    logic                       flash_act;
    logic                       blink_act;
    logic                       timer_off;
    logic [COUNT_W-1:0]         hold_cnt;
    logic [COUNT_W-1:0]         flash_len;
    logic [COUNT_W-1:0]         flash_num;
    logic [COUNT_W-1:0]         flash_pause;
    logic [COUNT_W-1:0]         flash_cnt;
    logic [COUNT_W-1:0]         blink_len;
    logic [COUNT_W-1:0]         blink_num;
    logic [COUNT_W-1:0]         blink_pause;
    logic [COUNT_W-1:0]         blink_cnt;
    logic [COUNT_W-1:0]         timer_reload;
    logic [COUNT_W-1:0]         timer_cnt;

    led_flash_blink_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 clk = ~clk;

    // load a new countdown period; at 16 timer bits no value needs saturating
    function automatic void arm_timer(input logic [COUNT_W-1:0] period);
        timer_off    = 1'b0;
        timer_reload = period;
    endfunction

    // applies one tick or command and returns the status beat it should give
    function automatic lfbs_result_t predict_status(input lfbs_item_t beat);
        logic         flag;
        logic         reload;
        lfbs_result_t res;
        flag   = (beat.quantity_or_flag != '0);
        reload = 1'b1;
        case (beat.action)
            ACT_TICK:
            begin
                reload = 1'b0;
                if (!timer_off)
                begin
                    if (timer_cnt != '0)
                        timer_cnt = timer_cnt - 16'd1;
                    // countdown expired: the active series takes one step
                    if (timer_cnt == '0)
                    begin
                        if (flash_act)
                        begin
                            if (lamp_lit)
                            begin
                                flash_cnt = flash_cnt + 16'd1;
                                if (flash_cnt >= flash_num)
                                begin
                                    // series over
                                    flash_cnt = '0;
                                    flash_act = 1'b0;
                                    if (hold_cnt == '0)
                                    begin
                                        if (cfg_blink_prio && blink_act)
                                        begin
                                            arm_timer(blink_pause);
                                            blink_cnt = '0;
                                        end
                                        else
                                        begin
                                            blink_act = 1'b0;
                                            timer_off = 1'b1;
                                        end
                                        lamp_lit = 1'b0;
                                    end
                                end
                                else
                                begin
                                    arm_timer(flash_pause);
                                    lamp_lit = 1'b0;
                                end
                            end
                            else
                            begin
                                arm_timer(flash_len);
                                lamp_lit = 1'b1;
                            end
                        end
                        else if (blink_act)
                        begin
                            if (lamp_lit)
                            begin
                                blink_cnt = blink_cnt + 16'd1;
                                if (blink_cnt >= blink_num)
                                begin
                                    blink_cnt = '0;
                                    arm_timer(blink_pause);
                                end
                                else
                                    arm_timer(blink_len);
                                lamp_lit = 1'b0;
                            end
                            else
                            begin
                                arm_timer(blink_len);
                                lamp_lit = 1'b1;
                            end
                        end
                        if (!timer_off)
                            timer_cnt = timer_reload;
                    end
                end
            end
            ACT_ENABLE:
                out_enable = flag;
            ACT_ON:
            begin
                // hold count saturates at the top
                if (flag && hold_cnt != '1)
                    hold_cnt = hold_cnt + 16'd1;
                if (!cfg_blink_prio)
                begin
                    flash_act = 1'b0;
                    blink_act = 1'b0;
                end
                timer_off = 1'b1;
                lamp_lit  = 1'b1;
            end
            ACT_OFF:
            begin
                if (flag && hold_cnt != '0)
                    hold_cnt = hold_cnt - 16'd1;
                if (hold_cnt == '0)
                begin
                    if (cfg_blink_prio)
                    begin
                        // resume a suspended series from its gap, if it has one
                        if (flash_act && flash_pause != '0)
                            arm_timer(flash_pause);
                        else if (blink_act && blink_pause != '0)
                        begin
                            arm_timer(blink_pause);
                            blink_cnt = '0;
                        end
                        else
                            timer_off = 1'b1;
                    end
                    else
                    begin
                        flash_act = 1'b0;
                        blink_act = 1'b0;
                        timer_off = 1'b1;
                    end
                    lamp_lit = 1'b0;
                end
            end
            ACT_FLASH:
            begin
                flash_act   = 1'b1;
                flash_len   = beat.on_duration;
                flash_num   = beat.quantity_or_flag;
                flash_pause = beat.gap_interval;
                flash_cnt   = '0;
                if (!cfg_blink_prio)
                    blink_act = 1'b0;
                if (hold_cnt == '0)
                begin
                    arm_timer('0);
                    lamp_lit = 1'b0;
                end
            end
            ACT_BLINK_ON:
            begin
                blink_act   = 1'b1;
                blink_len   = beat.on_duration;
                blink_num   = beat.quantity_or_flag;
                blink_pause = beat.gap_interval;
                blink_cnt   = '0;
                if (hold_cnt == '0 && !flash_act)
                begin
                    arm_timer('0);
                    lamp_lit = 1'b0;
                end
            end
            ACT_BLINK_OFF:
            begin
                if (blink_act)
                begin
                    blink_act = 1'b0;
                    flash_act = 1'b0;
                    if (hold_cnt == '0)
                        lamp_lit = 1'b0;
                    timer_off = 1'b1;
                end
            end
            default:
                reload = 1'b0;
        endcase
        // every command restarts the countdown
        if (reload)
            timer_cnt = timer_reload;
        res.led_pin       = (out_enable && lamp_lit) ? cfg_active_high : !cfg_active_high;
        res.led_lit       = lamp_lit;
        res.flash_running = flash_act;
        res.blink_running = blink_act;
        res.hold_level    = hold_cnt;
        return res;
    endfunction

    // mostly small values so the series move, now and then the full range
    function automatic logic [COUNT_W-1:0] span_value(input int unsigned narrow_max);
        if ($urandom_range(0, 99) < 12)
            return COUNT_W'($urandom_range(0, 65535));
        return COUNT_W'($urandom_range(0, narrow_max));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (fail_count < 40)
            $display("status mismatch on %s: got %0h, expected %0h", what, got, want);
        fail_count++;
    endtask

    // send one beat with random idle cycles ahead of it unless in the steady run, then log its status
    task automatic drive_beat(input lfbs_item_t beat, input logic typed,
                              input lfbs_result_t want);
        lfbs_result_t predicted;
        while (!steady_run && $urandom_range(0, 99) < 38)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(beat);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_status(beat);
        expected_status.push_back(typed ? want : predicted);
    endtask

    // hold the sender until every status beat is back
    task automatic wait_all_status();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic value);
        wait_all_status();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_ACTIVE_HIGH)
            cfg_active_high = value;
        else if (idx == REG_BLINK_PRIORITY)
            cfg_blink_prio = value;
    endtask

    // receiver back-pressure
    always @(posedge clk)
        m_tready <= steady_run || ($urandom_range(0, 99) >= 38);

    // status checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_status = lfbs_result_t'(m_tdata[RESULT_W-1:0]);
            if (expected_status.size() == 0)
                report_mismatch("unexpected beat", seen_status, 0);
            else
            begin
                want_status = expected_status.pop_front();
                if (seen_status.led_pin != want_status.led_pin)
                    report_mismatch("led_pin", seen_status.led_pin, want_status.led_pin);
                if (seen_status.led_lit != want_status.led_lit)
                    report_mismatch("led_lit", seen_status.led_lit, want_status.led_lit);
                if (seen_status.flash_running != want_status.flash_running)
                    report_mismatch("flash_running", seen_status.flash_running,
                                    want_status.flash_running);
                if (seen_status.blink_running != want_status.blink_running)
                    report_mismatch("blink_running", seen_status.blink_running,
                                    want_status.blink_running);
                if (seen_status.hold_level != want_status.hold_level)
                    report_mismatch("hold_level", seen_status.hold_level,
                                    want_status.hold_level);
            end
        end
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        lfbs_item_t  beat;
        int unsigned pick;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        steady_run = 1'b0;
        fail_count = 0;

        // predictor reset state
        cfg_active_high = 1'b1;
        cfg_blink_prio  = 1'b0;
        lamp_lit        = 1'b0;
        out_enable      = 1'b1;
        flash_act       = 1'b0;
        blink_act       = 1'b0;
        timer_off       = 1'b1;
        hold_cnt        = '0;
        flash_len       = '0;
        flash_num       = '0;
        flash_pause     = '0;
        flash_cnt       = '0;
        blink_len       = '0;
        blink_num       = '0;
        blink_pause     = '0;
        blink_cnt       = '0;
        timer_reload    = '0;
        timer_cnt       = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script
        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].kind == ROW_CFG)
                write_register(SCRIPT[i].qty[CFG_IDX_W-1:0], SCRIPT[i].dur[0]);
            else
            begin
                beat.action           = SCRIPT[i].action;
                beat.quantity_or_flag = SCRIPT[i].qty;
                beat.on_duration      = SCRIPT[i].dur;
                beat.gap_interval     = SCRIPT[i].gap;
                drive_beat(beat, SCRIPT[i].typed, SCRIPT[i].want);
            end
        end

        // random phases, one register setting each; phase 2 runs without idling
        for (int ph = 0; ph < 4; ph++)
        begin
            write_register(REG_ACTIVE_HIGH, PHASE_AH[ph]);
            write_register(REG_BLINK_PRIORITY, PHASE_PRIO[ph]);
            steady_run <= (ph == 2);
            for (int n = 0; n < 275; n++)
            begin
                if (ph == 0 && n == 140)
                    wait_all_status();
                // ticks dominate so the series get to step through their states
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    beat.action = ACT_TICK;
                else if (pick < 66)
                    beat.action = ACT_FLASH;
                else if (pick < 77)
                    beat.action = ACT_BLINK_ON;
                else if (pick < 84)
                    beat.action = ACT_ON;
                else if (pick < 92)
                    beat.action = ACT_OFF;
                else if (pick < 96)
                    beat.action = ACT_BLINK_OFF;
                else if (pick < 99)
                    beat.action = ACT_ENABLE;
                else
                    beat.action = ACT_UNUSED;
                beat.quantity_or_flag = span_value(3);
                beat.on_duration      = span_value(4);
                beat.gap_interval     = span_value(4);
                drive_beat(beat, 1'b0, '0);
            end
        end
        steady_run <= 1'b0;

        // two fixed on-requests, release one, then a tick
        beat.on_duration      = '0;
        beat.gap_interval     = '0;
        beat.action           = ACT_ON;
        beat.quantity_or_flag = 16'd1;
        drive_beat(beat, 1'b0, '0);
        drive_beat(beat, 1'b0, '0);
        beat.action = ACT_OFF;
        drive_beat(beat, 1'b0, '0);
        beat.action = ACT_TICK;
        drive_beat(beat, 1'b0, '0);

        wait_all_status();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
